FILE: rtl/ebbp_pkg.sv
package ebbp_pkg;

  // Blob layout
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned NAME_CHARS  = 13;
  localparam int unsigned CAP_BYTES   = 13;   // bytes 8..20

  localparam int unsigned POS_W  = 8;
  localparam int unsigned CIDX_W = 4;
  localparam int unsigned NIDX_W = 4;
  localparam int unsigned OFF_W  = 5;

  localparam logic [POS_W-1:0] POS_BLOCK_END = POS_W'(BLOCK_BYTES);
  localparam logic [POS_W-1:0] POS_HDR_END   = 8'd8;
  localparam logic [POS_W-1:0] POS_CAP_FIRST = 8'd8;
  localparam logic [POS_W-1:0] POS_CAP_LAST  = 8'd20;
  localparam logic [POS_W-1:0] POS_CLK_LO    = 8'd54;
  localparam logic [POS_W-1:0] POS_CLK_HI    = 8'd55;
  localparam logic [POS_W-1:0] POS_DESC_FIRST = 8'd72;
  localparam logic [POS_W-1:0] POS_DESC_END   = 8'd126;

  localparam logic [5:0] DESC_LEN   = 6'd18;
  localparam logic [5:0] DESC_LEN2  = 6'd36;

  // Offsets within one display descriptor
  localparam logic [OFF_W-1:0] OFF_CLK_LO = 5'd0;
  localparam logic [OFF_W-1:0] OFF_CLK_HI = 5'd1;
  localparam logic [OFF_W-1:0] OFF_TAG    = 5'd3;
  localparam logic [OFF_W-1:0] OFF_TEXT   = 5'd5;
  localparam logic [OFF_W-1:0] OFF_LAST   = 5'd17;

  // Captured byte slots (position minus 8)
  localparam logic [CIDX_W-1:0] CAP_MFG_HI  = 4'd0;
  localparam logic [CIDX_W-1:0] CAP_MFG_LO  = 4'd1;
  localparam logic [CIDX_W-1:0] CAP_PROD_LO = 4'd2;
  localparam logic [CIDX_W-1:0] CAP_PROD_HI = 4'd3;
  localparam logic [CIDX_W-1:0] CAP_SER_0   = 4'd4;
  localparam logic [CIDX_W-1:0] CAP_SER_1   = 4'd5;
  localparam logic [CIDX_W-1:0] CAP_SER_2   = 4'd6;
  localparam logic [CIDX_W-1:0] CAP_SER_3   = 4'd7;
  localparam logic [CIDX_W-1:0] CAP_WEEK    = 4'd8;
  localparam logic [CIDX_W-1:0] CAP_YEAR    = 4'd9;
  localparam logic [CIDX_W-1:0] CAP_VER     = 4'd10;
  localparam logic [CIDX_W-1:0] CAP_REV     = 4'd11;
  localparam logic [CIDX_W-1:0] CAP_INPUT   = 4'd12;

  localparam logic [7:0]  HDR_EDGE   = 8'h00;
  localparam logic [7:0]  HDR_MID    = 8'hFF;
  localparam logic [7:0]  VERSION_1  = 8'h01;
  localparam logic [7:0]  NAME_TAG   = 8'hFC;
  localparam logic [7:0]  CH_NEWLINE = 8'h0A;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  YEAR_MIN   = 8'h0F;
  localparam logic [7:0]  WEEK_NONE  = 8'hFF;
  localparam logic [7:0]  WEEK_END   = 8'h37;
  localparam logic [11:0] YEAR_BASE  = 12'd1990;
  localparam logic [2:0]  LETTER_HI  = 3'b010;   // +0x40 on a 5-bit code

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ebbp_in_t;

  typedef struct packed {
    logic        block_valid;
    logic [23:0] manufacturer_letters;
    logic [15:0] product_code;
    logic [31:0] serial_value;
    logic [11:0] manufacture_year;
    logic [5:0]  manufacture_week;
    logic [7:0]  version_number;
    logic [7:0]  revision_number;
    logic        digital_input;
    logic        name_present;
    logic [63:0] name_head;
    logic [39:0] name_tail;
  } ebbp_out_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0, 3'd7: v = HDR_EDGE;
      default:    v = HDR_MID;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/edid_base_block_parser_unit.sv
// A result appears in out_data in the cycle after the transfer of the byte marked last.
// One byte per cycle while in_ready holds; per-byte work is a position decode and an 8-bit add.
// in_ready drops only while a finished result waits in the output register and out_ready is low.
// Reset: synchronous on rst_n low; clears position, checksum, header and timing flags,
// the kept-name flag and the output valid. A last byte clears position, sum, hdr_ok, tclk, kp.
module edid_base_block_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ebbp_pkg::ebbp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ebbp_pkg::ebbp_out_t out_data
);
  import ebbp_pkg::*;

  // Parse state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic             tclk_r, tclk_nxt;
  logic             dclk_r, dclk_nxt;
  logic [7:0]       dtag_r, dtag_nxt;
  logic             nl_r, nl_nxt;       // newline seen
  logic             fail_r, fail_nxt;   // string rules broken
  logic             psp_r, psp_nxt;     // previous kept char was a space
  logic             kp_r, kp_nxt;       // kept name present

  logic [7:0] cap_r [CAP_BYTES];
  logic [7:0] cap_nxt [CAP_BYTES];
  logic [7:0] sbuf_r [NAME_CHARS];
  logic [7:0] sbuf_nxt [NAME_CHARS];
  logic [7:0] kch_r [NAME_CHARS];
  logic [7:0] kch_nxt [NAME_CHARS];

  // Output register
  logic      out_valid_r, out_valid_nxt;
  ebbp_out_t out_data_r, res;

  logic       in_acc, take, blob_end;
  logic [7:0] b;
  logic [5:0] dpos;
  logic [OFF_W-1:0] off;
  logic [NIDX_W-1:0] nidx;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign blob_end = in_acc && in_data.last_byte;
  assign take     = in_acc && (pos_r < POS_BLOCK_END);

  // Offset inside the current display descriptor (three of 18 bytes each)
  assign dpos = 6'(pos_r - POS_DESC_FIRST);
  always_comb begin
    if (dpos < DESC_LEN) begin
      off = OFF_W'(dpos);
    end else if (dpos < DESC_LEN2) begin
      off = OFF_W'(dpos - DESC_LEN);
    end else begin
      off = OFF_W'(dpos - DESC_LEN2);
    end
  end
  assign nidx = NIDX_W'(off - OFF_TEXT);

  // Per-byte update: header check, field capture, timing clock, name scan
  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    hdr_ok_nxt = hdr_ok_r;
    tclk_nxt   = tclk_r;
    dclk_nxt   = dclk_r;
    dtag_nxt   = dtag_r;
    nl_nxt     = nl_r;
    fail_nxt   = fail_r;
    psp_nxt    = psp_r;
    kp_nxt     = kp_r;
    cap_nxt    = cap_r;
    sbuf_nxt   = sbuf_r;
    kch_nxt    = kch_r;
    if (take) begin
      pos_nxt = pos_r + 1'b1;
      sum_nxt = sum_r + b;
      if (pos_r < POS_HDR_END) begin
        if (b != hdr_byte(pos_r[2:0])) begin
          hdr_ok_nxt = 1'b0;
        end
      end else if (pos_r <= POS_CAP_LAST) begin
        cap_nxt[CIDX_W'(pos_r - POS_CAP_FIRST)] = b;
      end else if (pos_r == POS_CLK_LO || pos_r == POS_CLK_HI) begin
        if (b != 8'h00) begin
          tclk_nxt = 1'b1;
        end
      end else if (pos_r >= POS_DESC_FIRST && pos_r < POS_DESC_END) begin
        if (off == OFF_CLK_LO) begin
          // Start of a descriptor: drop the previous scan
          dclk_nxt = (b != 8'h00);
          dtag_nxt = 8'h00;
          nl_nxt   = 1'b0;
          fail_nxt = 1'b0;
          psp_nxt  = 1'b0;
          for (int k = 0; k < NAME_CHARS; k++) begin
            sbuf_nxt[k] = 8'h00;
          end
        end else if (off == OFF_CLK_HI) begin
          if (b != 8'h00) begin
            dclk_nxt = 1'b1;
          end
        end else if (off == OFF_TAG) begin
          dtag_nxt = b;
        end else if (off >= OFF_TEXT) begin
          if (b inside {[8'h21:8'h7E]}) begin
            sbuf_nxt[nidx] = b;
            psp_nxt = 1'b0;
          end else if (!nl_r) begin
            if (b == CH_NEWLINE) begin
              if (nidx != '0 && psp_r) begin
                fail_nxt = 1'b1;
              end
              nl_nxt  = 1'b1;
              psp_nxt = 1'b0;
            end else if (b == CH_SPACE) begin
              sbuf_nxt[nidx] = b;
              psp_nxt = 1'b1;
            end else begin
              fail_nxt = 1'b1;
            end
          end else if (b != CH_SPACE) begin
            fail_nxt = 1'b1;
          end
          if (off == OFF_LAST) begin
            // Trailing space without a newline fails the name
            if (!nl_nxt && psp_nxt) begin
              fail_nxt = 1'b1;
            end
            if (!dclk_r && dtag_r == NAME_TAG) begin
              kp_nxt  = !fail_nxt;
              kch_nxt = sbuf_nxt;
            end
          end
        end
      end
    end
  end

  // Result decode from the state as it stands after the last byte
  always_comb begin
    logic ok, yr_ok;
    logic [15:0] code;
    logic [7:0]  wk, yr;
    ok = (pos_nxt == POS_BLOCK_END) && (sum_nxt == 8'h00) && hdr_ok_nxt &&
         (cap_nxt[CAP_VER] == VERSION_1) && tclk_nxt;
    code  = {cap_nxt[CAP_MFG_HI], cap_nxt[CAP_MFG_LO]};
    wk    = cap_nxt[CAP_WEEK];
    yr    = cap_nxt[CAP_YEAR];
    yr_ok = (yr > YEAR_MIN) && (wk != WEEK_NONE);
    res = '0;
    if (ok) begin
      res.block_valid = 1'b1;
      res.manufacturer_letters = {LETTER_HI, code[14:10], LETTER_HI, code[9:5],
                                  LETTER_HI, code[4:0]};
      res.product_code = {cap_nxt[CAP_PROD_HI], cap_nxt[CAP_PROD_LO]};
      res.serial_value = {cap_nxt[CAP_SER_3], cap_nxt[CAP_SER_2],
                          cap_nxt[CAP_SER_1], cap_nxt[CAP_SER_0]};
      if (yr_ok) begin
        res.manufacture_year = {4'h0, yr} + YEAR_BASE;
        if (wk != 8'h00 && wk < WEEK_END) begin
          res.manufacture_week = wk[5:0];
        end
      end
      res.version_number  = cap_nxt[CAP_VER];
      res.revision_number = cap_nxt[CAP_REV];
      res.digital_input   = cap_nxt[CAP_INPUT][7];
      if (kp_nxt) begin
        res.name_present = 1'b1;
        for (int k = 0; k < 8; k++) begin
          res.name_head[63-8*k -: 8] = kch_nxt[k];
        end
        for (int k = 8; k < NAME_CHARS; k++) begin
          res.name_tail[39-8*(k-8) -: 8] = kch_nxt[k];
        end
      end
    end
  end

  // Hold a result until its transfer; load a fresh one on the last byte
  always_comb begin
    if (blob_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sum_r       <= '0;
      hdr_ok_r    <= 1'b1;
      tclk_r      <= 1'b0;
      dclk_r      <= 1'b0;
      dtag_r      <= '0;
      nl_r        <= 1'b0;
      fail_r      <= 1'b0;
      psp_r       <= 1'b0;
      kp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      dclk_r      <= dclk_nxt;
      dtag_r      <= dtag_nxt;
      nl_r        <= nl_nxt;
      fail_r      <= fail_nxt;
      psp_r       <= psp_nxt;
      if (blob_end) begin
        // Back to the reset state for the next blob
        pos_r    <= '0;
        sum_r    <= '0;
        hdr_ok_r <= 1'b1;
        tclk_r   <= 1'b0;
        kp_r     <= 1'b0;
      end else begin
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
        hdr_ok_r <= hdr_ok_nxt;
        tclk_r   <= tclk_nxt;
        kp_r     <= kp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_r  <= cap_nxt;
    sbuf_r <= sbuf_nxt;
    kch_r  <= kch_nxt;
    if (blob_end) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    blob_end |=> out_valid_r)
    else $error("no result after last byte");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    blob_end |=> (pos_r == '0 && sum_r == 8'h00 && hdr_ok_r && !kp_r))
    else $error("state not cleared after last byte");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_BLOCK_END)
    else $error("byte position beyond block");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.block_valid) |->
      (out_data_r.manufacturer_letters == '0 && out_data_r.serial_value == '0 &&
       out_data_r.name_present == 1'b0 && out_data_r.version_number == '0))
    else $error("invalid block with nonzero fields");

  a_no_name_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.name_present) |->
      (out_data_r.name_head == '0 && out_data_r.name_tail == '0))
    else $error("name characters without a name");

endmodule
